FILE: sv/linear_probe_hash_set_macros.svh
// ----------------------------------------------------------------------------
// linear_probe_hash_set_macros
// assertion macros for the hash set; empty bodies for synthesis
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_SET_MACROS_SVH
`define LINEAR_PROBE_HASH_SET_MACROS_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define LPHS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lphs assertion failed");
// checked on every edge, reset included
`define LPHS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("lphs assertion failed");
`else
`define LPHS_ASSERT(lbl, prop)
`define LPHS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: sv/lphs_pkg.sv
// ----------------------------------------------------------------------------
// lphs_pkg
// constants, codes and helpers for the linear probing hash set
// ----------------------------------------------------------------------------
package lphs_pkg;

  localparam int SLOTS      = 256;
  localparam int ADDR_W     = $clog2(SLOTS);
  localparam int SCNT_W     = ADDR_W + 1;
  localparam int KEY_W      = 64;
  localparam int KEY_BYTES  = KEY_W / 8;
  localparam int HASH_W     = 32;
  localparam int KB_W       = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // remainder unit: bits per cycle and steps per hash
  localparam int DIV_STEP  = 4;
  localparam int DIV_ITER  = HASH_W / DIV_STEP;
  localparam int DIV_CNT_W = $clog2(DIV_ITER);

  // load limit n*7/10 as n * (7 * ceil(2^19/10)) >> 19
  localparam int THR_SHIFT = 19;
  localparam int THR_MUL   = 7 * 52429;
  localparam int THR_PRD_W = SCNT_W + 19;

  localparam logic [KB_W-1:0]   KB_RESET   = KB_W'(8);
  localparam logic [SCNT_W-1:0] SLOTS_INIT = SCNT_W'(SLOTS);

  typedef enum logic [2:0] {
    FN_ADD    = 3'd0,
    FN_SEARCH = 3'd1,
    FN_FIRST  = 3'd2,
    FN_NEXT   = 3'd3,
    FN_LAST   = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_END       = 3'd4,
    ST_ZERO      = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_BYTES = 2'd0,
    CFG_SLOTS     = 2'd1
  } cfg_idx_e;

  function automatic logic [KEY_W-1:0] key_mask(input logic [KB_W-1:0] kb);
    logic [KB_W-1:0]  nb;
    logic [KEY_W-1:0] m;
    nb = kb;
    if (nb < KB_W'(4)) nb = KB_W'(4);
    if (nb > KB_W'(KEY_BYTES)) nb = KB_W'(KEY_BYTES);
    for (int b = 0; b < KEY_BYTES; b++) begin
      m[b*8 +: 8] = (KB_W'(b) < nb) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  function automatic logic [SCNT_W-1:0] used_slots(input logic [SCNT_W-1:0] raw);
    logic [SCNT_W-1:0] n;
    n = raw;
    if (n == '0) n = SCNT_W'(1);
    if (n > SLOTS_INIT) n = SLOTS_INIT;
    return n;
  endfunction

endpackage

FILE: sv/lphs_if.sv
// ----------------------------------------------------------------------------
// lphs_if
// valid/ready channels of the hash set: item in, result out, register write
// ----------------------------------------------------------------------------
interface lphs_in_if import lphs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       func;
  logic [KEY_W-1:0] key;
  modport source (output valid, func, key, input ready);
  modport sink   (input valid, func, key, output ready);
endinterface

interface lphs_out_if import lphs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [KEY_W-1:0]  entry;
  logic [ADDR_W-1:0] slot;
  modport source (output valid, status, entry, slot, input ready);
  modport sink   (input valid, status, entry, slot, output ready);
endinterface

interface lphs_cfg_if import lphs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

FILE: sv/linear_probe_hash_set.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_set
// hash set of up to 8-byte keys, open addressing with linear probing
// ----------------------------------------------------------------------------
// One item is taken at a time and its result waits in an output register, so
// a new item is accepted while the previous result is still unclaimed. Add
// and search first reduce the low four key bytes modulo slots_in_use in a
// remainder unit that retires four bits a cycle, then probe the single-port
// table one slot at a time, reading each slot visited and then comparing it;
// get first/next/last scan slot by slot in the same way, up to slots_in_use
// slots on a sparse table. The done state hands the result to the output
// register once that register is free, and the block then returns to idle to
// take the next item. An add that stores writes the table in its compare
// cycle. Slot occupancy is held in per-slot valid flops cleared by reset, so
// the block is ready right after reset with no clearing pass. Register writes
// are always taken, one per cycle.
`include "linear_probe_hash_set_macros.svh"

module linear_probe_hash_set import lphs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lphs_cfg_if.sink  cfg_i,
  lphs_in_if.sink   in_i,
  lphs_out_if.source out_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_RD   = 5'b00100,
    S_CHK  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [KB_W-1:0]   kb_q;
  logic [SCNT_W-1:0] siu_q;

  logic [2:0]           func_q, func_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [KEY_W-1:0]     mask_q, mask_d;
  logic [SCNT_W-1:0]    n_q, n_d;
  logic [SCNT_W-1:0]    thr_q, thr_d;
  logic [SCNT_W-1:0]    pos_q, pos_d;
  logic [SCNT_W-1:0]    pcnt_q, pcnt_d;
  logic [ADDR_W-1:0]    home_q, home_d;
  logic [HASH_W-1:0]    dvd_q, dvd_d;
  logic [SCNT_W-1:0]    rem_q, rem_d;
  logic [DIV_CNT_W-1:0] dcnt_q, dcnt_d;
  logic [2:0]           res_st_q, res_st_d;
  logic [KEY_W-1:0]     res_ent_q, res_ent_d;

  logic [ADDR_W-1:0] cursor_q, cursor_d;
  logic              cset_q, cset_d;
  logic [SCNT_W-1:0] count_q, count_d;

  logic              out_vld_q;
  logic [2:0]        out_st_q;
  logic [KEY_W-1:0]  out_ent_q;
  logic [ADDR_W-1:0] out_slot_q;
  logic              out_load;

  logic [KEY_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0] vld_q;
  logic [KEY_W-1:0] rdata_q;
  logic             vbit_q;
  logic             mem_we;

  logic [KEY_W-1:0]     in_mask, in_key, slot_val;
  logic [SCNT_W-1:0]    in_n, nxt_pos, nxt_cnt, next_start;
  logic [THR_PRD_W-1:0] thr_prd;
  logic [SCNT_W-1:0]    div_r, div_t;
  logic [HASH_W-1:0]    div_d;
  logic                 is_probe, in_xfer;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;

  assign out_o.valid  = out_vld_q;
  assign out_o.status = out_st_q;
  assign out_o.entry  = out_ent_q;
  assign out_o.slot   = out_slot_q;

  assign in_mask    = key_mask(kb_q);
  assign in_key     = in_i.key & in_mask;
  assign in_n       = used_slots(siu_q);
  assign thr_prd    = THR_PRD_W'(in_n) * THR_PRD_W'(THR_MUL);
  assign next_start = cset_q ? (SCNT_W'(cursor_q) + SCNT_W'(1)) : '0;

  assign is_probe = (func_q == FN_ADD) || (func_q == FN_SEARCH);
  assign slot_val = rdata_q & mask_q & {KEY_W{vbit_q}};
  assign nxt_pos  = pos_q + SCNT_W'(1);
  assign nxt_cnt  = pcnt_q + SCNT_W'(1);
  assign out_load = (state_q == S_DONE) && (!out_vld_q || out_o.ready);
  assign mem_we   = (state_q == S_CHK) && (func_q == FN_ADD) && (slot_val == '0)
                    && (count_q <= thr_q);

  // remainder unit, DIV_STEP quotient bits per cycle
  always_comb begin
    div_r = rem_q;
    div_d = dvd_q;
    div_t = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      div_t = {div_r[ADDR_W-1:0], div_d[HASH_W-1]};
      div_d = div_d << 1;
      if (div_t >= n_q) div_t = div_t - n_q;
      div_r = div_t;
    end
  end

  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    key_d     = key_q;
    mask_d    = mask_q;
    n_d       = n_q;
    thr_d     = thr_q;
    pos_d     = pos_q;
    pcnt_d    = pcnt_q;
    home_d    = home_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    dcnt_d    = dcnt_q;
    res_st_d  = res_st_q;
    res_ent_d = res_ent_q;
    cursor_d  = cursor_q;
    cset_d    = cset_q;
    count_d   = count_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          func_d    = in_i.func;
          key_d     = in_key;
          mask_d    = in_mask;
          n_d       = in_n;
          thr_d     = thr_prd[THR_SHIFT +: SCNT_W];
          res_ent_d = '0;
          dvd_d     = in_key[HASH_W-1:0];
          rem_d     = '0;
          dcnt_d    = '0;
          unique case (in_i.func) inside
            FN_ADD, FN_SEARCH: begin
              if (in_key == '0) begin
                res_st_d = ST_ZERO;
                state_d  = S_DONE;
              end else begin
                state_d = S_DIV;
              end
            end
            FN_FIRST: begin
              cset_d  = 1'b0;
              pos_d   = '0;
              state_d = S_RD;
            end
            FN_NEXT: begin
              pos_d = next_start;
              if (next_start >= in_n) begin
                res_st_d = ST_END;
                state_d  = S_DONE;
              end else begin
                state_d = S_RD;
              end
            end
            FN_LAST: begin
              pos_d   = in_n - SCNT_W'(1);
              state_d = S_RD;
            end
            default: begin
              res_st_d = ST_NOT_FOUND;
              state_d  = S_DONE;
            end
          endcase
        end
      end
      S_DIV: begin
        dvd_d  = div_d;
        rem_d  = div_r;
        dcnt_d = dcnt_q + DIV_CNT_W'(1);
        if (dcnt_q == DIV_CNT_W'(DIV_ITER - 1)) begin
          pos_d   = div_r;
          home_d  = div_r[ADDR_W-1:0];
          pcnt_d  = '0;
          cset_d  = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        state_d = S_DONE;
        if (is_probe) begin
          if (slot_val == '0) begin
            cursor_d = pos_q[ADDR_W-1:0];
            if (func_q == FN_SEARCH) begin
              res_st_d = ST_NOT_FOUND;
            end else if (count_q > thr_q) begin
              res_st_d = ST_FULL;
            end else begin
              res_st_d  = ST_OK;
              res_ent_d = key_q;
              count_d   = count_q + SCNT_W'(1);
            end
          end else if (slot_val == key_q) begin
            cursor_d  = pos_q[ADDR_W-1:0];
            res_st_d  = (func_q == FN_SEARCH) ? ST_OK : ST_EXISTS;
            res_ent_d = slot_val;
          end else if (nxt_cnt == n_q) begin
            cursor_d = home_q;
            res_st_d = (func_q == FN_SEARCH) ? ST_NOT_FOUND : ST_FULL;
          end else begin
            pcnt_d  = nxt_cnt;
            pos_d   = (nxt_pos == n_q) ? '0 : nxt_pos;
            state_d = S_RD;
          end
        end else if (slot_val != '0) begin
          cursor_d  = pos_q[ADDR_W-1:0];
          cset_d    = 1'b1;
          res_st_d  = ST_OK;
          res_ent_d = slot_val;
        end else if (func_q == FN_LAST) begin
          if (pos_q == '0) begin
            res_st_d = ST_END;
          end else begin
            pos_d   = pos_q - SCNT_W'(1);
            state_d = S_RD;
          end
        end else if (nxt_pos >= n_q) begin
          res_st_d = ST_END;
        end else begin
          pos_d   = nxt_pos;
          state_d = S_RD;
        end
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      kb_q     <= KB_RESET;
      siu_q    <= SLOTS_INIT;
      cursor_q <= '0;
      cset_q   <= 1'b0;
      count_q  <= '0;
      dcnt_q   <= '0;
      pcnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      cset_q   <= cset_d;
      count_q  <= count_d;
      dcnt_q   <= dcnt_d;
      pcnt_q   <= pcnt_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.idx)
          CFG_KEY_BYTES: kb_q  <= cfg_i.wdata[KB_W-1:0];
          CFG_SLOTS:     siu_q <= cfg_i.wdata[SCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    key_q     <= key_d;
    mask_q    <= mask_d;
    n_q       <= n_d;
    thr_q     <= thr_d;
    pos_q     <= pos_d;
    home_q    <= home_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    res_st_q  <= res_st_d;
    res_ent_q <= res_ent_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_st_q   <= res_st_q;
      out_ent_q  <= res_ent_q;
      out_slot_q <= cursor_q;
    end
  end

  // slot table, one read and one write port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[pos_q[ADDR_W-1:0]] <= key_q;
    rdata_q <= mem[pos_q[ADDR_W-1:0]];
    vbit_q  <= vld_q[pos_q[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[pos_q[ADDR_W-1:0]] <= 1'b1;
    end
  end

  `LPHS_ASSERT(a_chk_in_range, (state_q == S_CHK) |-> (pos_q < n_q))
  `LPHS_ASSERT(a_write_only_add, mem_we |-> (func_q == FN_ADD) && (slot_val == '0))
  `LPHS_ASSERT(a_result_from_done, $rose(out_vld_q) |-> $past(state_q == S_DONE))
  `LPHS_ASSERT_ALWAYS(a_ready_no_op, in_i.ready |-> !mem_we)

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the linear probing hash set against its own model of table and cursor
// ----------------------------------------------------------------------------
// A short directed sequence goes first: empty-table scans, zero keys, probe
// wrap, duplicate adds and unknown functions. Six random phases follow, each
// with a new register setting and a small key pool, so that adds, searches
// and scans hit the same keys. Both sides stall at random. The receiver holds
// off for a long stretch once, and the sender pauses once until the block
// drains. Every result is checked field by field in order.
module testbench;
  import lphs_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_PHASE     = 1;
  localparam int PAUSE_PHASE    = 3;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 62;
  localparam int POOL_SIZE      = 16;
  localparam int IDLE_LIGHT     = 6;
  localparam int IDLE_HEAVY     = 49;
  localparam int MIN_KEY_BYTES  = 4;
  localparam int LOAD_NUM       = 7;
  localparam int LOAD_DEN       = 10;
  localparam int MAX_PRINTS     = 200;
  localparam logic [2:0] FN_TOP = 3'd7;

  localparam int PHASE_KB    [PHASES] = '{5, 4, 0, 6, 15, 8};
  localparam int PHASE_SLOTS [PHASES] = '{37, 8, 0, 1, 511, 256};

  typedef enum logic [1:0] {PROBE_EMPTY, PROBE_HIT, PROBE_MISS} probe_e;

  typedef struct packed {
    logic [2:0]       fn;
    logic [KEY_W-1:0] key;
  } set_op_t;

  typedef struct packed {
    status_e           status;
    logic [KEY_W-1:0]  entry;
    logic [ADDR_W-1:0] slot;
  } set_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lphs_in_if  in_if ();
  lphs_out_if out_if ();
  lphs_cfg_if cfg_if ();

  linear_probe_hash_set uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // model state
  logic [KEY_W-1:0]  set_tbl [SLOTS];
  int                n_entries;
  int                cur_pos;
  logic              cur_valid;
  logic [KB_W-1:0]   cfg_kb;
  logic [SCNT_W-1:0] cfg_slots;

  set_op_t          op_queue [$];
  set_result_t      expected_results [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int n_pushed;
  int n_accepted;
  int n_results;
  int n_cfg_writes;
  int n_errors;
  int idle_run;
  int send_idle_pct;
  int recv_idle_pct;
  logic recv_hold;
  int status_seen [8];

  function automatic logic [KEY_W-1:0] sig_mask();
    int nb;
    nb = cfg_kb;
    if (nb < MIN_KEY_BYTES) nb = MIN_KEY_BYTES;
    if (nb > KEY_BYTES) nb = KEY_BYTES;
    if (nb == KEY_BYTES) return {KEY_W{1'b1}};
    return (KEY_W'(1) << (nb * 8)) - KEY_W'(1);
  endfunction

  function automatic int live_slots();
    int n;
    n = cfg_slots;
    if (n == 0) n = 1;
    if (n > SLOTS) n = SLOTS;
    return n;
  endfunction

  function automatic int first_used(int start, int n, logic [KEY_W-1:0] m);
    for (int p = start; p < n; p++) begin
      if ((set_tbl[p] & m) != '0) return p;
    end
    return -1;
  endfunction

  function automatic int last_used(int n, logic [KEY_W-1:0] m);
    for (int p = n - 1; p >= 0; p--) begin
      if ((set_tbl[p] & m) != '0) return p;
    end
    return -1;
  endfunction

  function automatic set_result_t apply_op(logic [2:0] fn, logic [KEY_W-1:0] raw_key);
    logic [KEY_W-1:0] m;
    logic [KEY_W-1:0] k;
    int               n;
    int               home;
    int               pos;
    int               p;
    probe_e           outcome;
    set_result_t      r;
    m = sig_mask();
    k = raw_key & m;
    n = live_slots();
    r.status = ST_NOT_FOUND;
    r.entry  = '0;
    case (fn) inside
      FN_ADD, FN_SEARCH: begin
        if (k == '0) begin
          r.status = ST_ZERO;
        end else begin
          home = int'(k[31:0] % n);
          pos = home;
          outcome = PROBE_MISS;
          cur_valid = 1'b1;
          for (int i = 0; i < n; i++) begin
            if ((set_tbl[pos] & m) == '0) begin
              outcome = PROBE_EMPTY;
              break;
            end
            if ((set_tbl[pos] & m) == k) begin
              outcome = PROBE_HIT;
              break;
            end
            pos = (pos + 1 == n) ? 0 : pos + 1;
          end
          cur_pos = (outcome == PROBE_MISS) ? home : pos;
          if (outcome == PROBE_HIT) begin
            if (fn == FN_ADD) r.status = ST_EXISTS;
            else r.status = ST_OK;
            r.entry = set_tbl[cur_pos] & m;
          end else if (fn == FN_SEARCH) begin
            r.status = ST_NOT_FOUND;
          end else if (outcome == PROBE_MISS || n_entries > (n * LOAD_NUM) / LOAD_DEN) begin
            r.status = ST_FULL;
          end else begin
            set_tbl[cur_pos] = k;
            n_entries++;
            r.status = ST_OK;
            r.entry = k;
          end
        end
      end
      FN_FIRST, FN_NEXT, FN_LAST: begin
        if (fn == FN_FIRST) begin
          cur_valid = 1'b0;
          p = first_used(0, n, m);
        end else if (fn == FN_NEXT) begin
          p = first_used(cur_valid ? cur_pos + 1 : 0, n, m);
        end else begin
          p = last_used(n, m);
        end
        if (p < 0) begin
          r.status = ST_END;
        end else begin
          cur_pos = p;
          cur_valid = 1'b1;
          r.status = ST_OK;
          r.entry = set_tbl[p] & m;
        end
      end
      default: r.status = ST_NOT_FOUND;
    endcase
    r.slot = ADDR_W'(cur_pos);
    return r;
  endfunction

  function automatic logic [2:0] pick_func();
    int d;
    d = $urandom_range(99);
    if (d < 25) return FN_ADD;
    if (d < 55) return FN_SEARCH;
    if (d < 63) return FN_FIRST;
    if (d < 83) return FN_NEXT;
    if (d < 90) return FN_LAST;
    if (d < 94) return 3'($urandom_range(FN_TOP, FN_LAST + 1));
    return FN_NEXT;
  endfunction

  function automatic logic [KEY_W-1:0] make_key();
    logic [KEY_W-1:0] m;
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] noise;
    int               d;
    m = sig_mask();
    base = key_pool[$urandom_range(POOL_SIZE - 1)];
    noise = {$urandom, $urandom};
    d = $urandom_range(99);
    // significant bytes all zero
    if (d < 8) return noise & ~m;
    if (d < 40) return base;
    // same key once masked
    if (d < 62) return (base & m) | (noise & ~m);
    // same home slot, different key
    if (d < 75) return base + KEY_W'(live_slots()) * KEY_W'($urandom_range(3, 1));
    return noise;
  endfunction

  task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
    if (n_errors < MAX_PRINTS)
      $display("mismatch on result %0d, %s: got %h, expected %h", n_results, what, got, want);
    n_errors++;
  endtask

  task automatic push_item(logic [2:0] fn, logic [KEY_W-1:0] key);
    set_op_t op;
    op.fn = fn;
    op.key = key;
    op_queue.push_back(op);
    n_pushed++;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_pushed || expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idle(int send_pct, int recv_pct);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  task automatic hold_receiver(int cycles);
    fork
      begin
        recv_hold <= 1'b1;
        repeat (cycles) @(posedge clk_i);
        recv_hold <= 1'b0;
      end
    join_none
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.idx   <= idx;
    cfg_if.wdata <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_KEY_BYTES) cfg_kb = data[KB_W-1:0];
    else cfg_slots = data[SCNT_W-1:0];
    n_cfg_writes++;
  endtask

  task automatic run_phase(int ph);
    logic [CFG_DATA_W-1:0] wd;
    if (ph < 2) set_idle(IDLE_LIGHT, IDLE_HEAVY);
    else if (ph < 4) set_idle(IDLE_HEAVY, IDLE_LIGHT);
    else set_idle(0, 0);
    // park the cursor high before the table shrinks
    push_item(FN_LAST, '0);
    wait_drained();
    wd = CFG_DATA_W'($urandom);
    wd[KB_W-1:0] = KB_W'(PHASE_KB[ph]);
    write_reg(CFG_KEY_BYTES, wd);
    wd = CFG_DATA_W'($urandom);
    wd[SCNT_W-1:0] = SCNT_W'(PHASE_SLOTS[ph]);
    write_reg(CFG_SLOTS, wd);
    for (int j = 0; j < 6; j++) key_pool[$urandom_range(POOL_SIZE - 1)] = {$urandom, $urandom};
    push_item(FN_NEXT, '0);
    if (ph == HOLD_PHASE) hold_receiver(HOLD_CYCLES);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (ph == PAUSE_PHASE && i == PHASE_ITEMS / 2) wait_drained();
      push_item(pick_func(), make_key());
    end
    wait_drained();
  endtask

  // item driver
  always @(posedge clk_i) begin
    set_op_t op;
    if (rst_ni) begin
      if (!in_if.valid || in_if.ready) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          op = op_queue.pop_front();
          in_if.valid <= 1'b1;
          in_if.func  <= op.fn;
          in_if.key   <= op.key;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver
  always @(posedge clk_i) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else out_if.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: check results first, then predict the item taken at this edge
  always @(posedge clk_i) begin
    set_result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        n_results++;
        status_seen[out_if.status]++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_if.entry, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_if.status !== want.status)
            report_mismatch("status", KEY_W'(out_if.status), KEY_W'(want.status));
          if (out_if.entry !== want.entry)
            report_mismatch("entry", out_if.entry, want.entry);
          if (out_if.slot !== want.slot)
            report_mismatch("slot", KEY_W'(out_if.slot), KEY_W'(want.slot));
        end
      end
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(apply_op(in_if.func, in_if.key));
        n_accepted++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_run <= 0;
    end else if (idle_run >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("testbench: errors");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.func   = FN_ADD;
    in_if.key    = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.idx   = CFG_KEY_BYTES;
    cfg_if.wdata = '0;
    recv_hold    = 1'b0;
    rst_ni       = 1'b0;
    for (int s = 0; s < SLOTS; s++) set_tbl[s] = '0;
    n_entries = 0;
    cur_pos = 0;
    cur_valid = 1'b0;
    cfg_kb = KB_RESET;
    cfg_slots = SLOTS_INIT;
    n_pushed = 0;
    n_accepted = 0;
    n_results = 0;
    n_cfg_writes = 0;
    n_errors = 0;
    idle_run = 0;
    send_idle_pct = IDLE_LIGHT;
    recv_idle_pct = IDLE_HEAVY;
    for (int s = 0; s < 8; s++) status_seen[s] = 0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // scans of an empty table
    push_item(FN_FIRST, '0);
    push_item(FN_NEXT, '0);
    push_item(FN_LAST, '0);
    // zero keys
    push_item(FN_ADD, '0);
    push_item(FN_SEARCH, '0);
    push_item(FN_SEARCH, 64'h1);
    // last slot, then a wrap to slot zero
    push_item(FN_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(FN_ADD, 64'h0000_0001_0000_00FF);
    push_item(FN_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(FN_SEARCH, 64'h0000_0001_0000_00FF);
    push_item(FN_ADD, 64'h8000_0000_0000_0100);
    push_item(FN_ADD, 64'h0123_4567_89AB_CDEF);
    push_item(FN_FIRST, '0);
    push_item(FN_NEXT, '0);
    push_item(FN_NEXT, '0);
    push_item(FN_NEXT, '0);
    push_item(FN_NEXT, '0);
    push_item(FN_LAST, '0);
    push_item(FN_NEXT, '0);
    push_item(FN_SEARCH, 64'h8000_0000_0000_0100);
    push_item(FN_NEXT, '0);
    for (int f = FN_LAST + 1; f <= FN_TOP; f++) push_item(3'(f), {$urandom, $urandom});
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) run_phase(ph);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", KEY_W'(expected_results.size()), '0);
    $display("summary: %0d items, %0d results, %0d register writes over %0d settings",
             n_accepted, n_results, n_cfg_writes, PHASES + 1);
    $display("summary: ok %0d, exists %0d, not found %0d, full %0d, end %0d, zero key %0d",
             status_seen[ST_OK], status_seen[ST_EXISTS], status_seen[ST_NOT_FOUND],
             status_seen[ST_FULL], status_seen[ST_END], status_seen[ST_ZERO]);
    if (n_errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
